// ===== rtl/core/onewire_search_rom_responder_macros.svh =====
// ----------------------------------------------------------------------------
// Search ROM responder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_SEARCH_ROM_RESPONDER_MACROS_SVH
`define ONEWIRE_SEARCH_ROM_RESPONDER_MACROS_SVH

// Same-cycle implication.
`define OSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/osr_pkg.sv =====
// ----------------------------------------------------------------------------
// Search ROM responder package
// Sizes, item kinds, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package osr_pkg;

  localparam int MAX_DEVICES = 8;
  localparam int ID_WIDTH    = 64;
  localparam int ID_IDX_W    = (ID_WIDTH > 1) ? $clog2(ID_WIDTH) : 1;
  localparam int MASK_W      = 8;
  localparam int MASK_LANES  = (MAX_DEVICES < MASK_W) ? MAX_DEVICES : MASK_W;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 3;
  localparam int DEV_ID_W = 64;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 4;
  localparam int PHASE_W  = 2;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [POS_W-1:0]   POS_LIMIT      = POS_W'(64);
  localparam logic [POS_W-1:0]   BIT_SIZE_RST   = POS_W'(8);
  localparam logic [COUNT_W-1:0] DEV_COUNT_RST  = COUNT_W'(8);

  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_DIR    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESET = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_SIZE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 1'd1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESET,
    OP_START,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef struct packed {
    logic capture;
    op_t  op;
  } osr_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               search_mode;
    logic [PHASE_W-1:0] phase;
  } osr_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/osr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Search ROM responder controller
// Accepts one item, then decodes it into a single datapath operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire osr_pkg::osr_status_t sts,
  output      osr_pkg::osr_cmd_t    cmd
);
  import osr_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        busy = 1'b1;
        // Reads and writes outside their mode and phase are dropped here.
        unique case (sts.kind)
          KIND_LOAD:  cmd.op = OP_LOAD;
          KIND_RESET: cmd.op = OP_RESET;
          KIND_START: cmd.op = OP_START;
          KIND_READ: begin
            if (sts.search_mode && (sts.phase == PHASE_FIRST || sts.phase == PHASE_SECOND)) begin
              cmd.op = OP_READ;
            end
          end
          KIND_WRITE: begin
            if (sts.search_mode && sts.phase == PHASE_DIR) begin
              cmd.op = OP_WRITE;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/osr_dp.sv =====
// ----------------------------------------------------------------------------
// Search ROM responder datapath
// Device ID lanes, search flags, bit position, phase and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osr_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire osr_pkg::osr_cmd_t               cmd,
  output      osr_pkg::osr_status_t            sts,
  input  wire logic [osr_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [osr_pkg::INDEX_W-1:0]     in_device_index,
  input  wire logic [osr_pkg::DEV_ID_W-1:0]    in_device_id,
  input  wire logic                            in_direction,
  input  wire logic                            cfg_we,
  input  wire logic [osr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [osr_pkg::CFG_W-1:0]       cfg_data,
  output      logic                            out_valid,
  output      logic                            out_bus_bit,
  output      logic [osr_pkg::MASK_W-1:0]      out_in_search_mask
);
  import osr_pkg::*;

  // Captured item.
  logic [KIND_W-1:0]   kind_r;
  logic [INDEX_W-1:0]  index_r;
  logic [ID_WIDTH-1:0] new_id_r;
  logic                dir_r;

  // Configuration.
  logic [POS_W-1:0]   bit_size_r;
  logic [COUNT_W-1:0] dev_count_r;

  // Search state.
  logic [ID_WIDTH-1:0]    id_store_r [MAX_DEVICES];
  logic [MAX_DEVICES-1:0] in_search_r;
  logic [MAX_DEVICES-1:0] in_search_nxt;
  logic                   mode_r;
  logic                   mode_nxt;
  logic [PHASE_W-1:0]     phase_r;
  logic [PHASE_W-1:0]     phase_nxt;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_nxt;

  // Result register.
  logic              valid_r;
  logic              bus_bit_r;
  logic [MASK_W-1:0] mask_r;

  // Per-lane terms.
  logic [MAX_DEVICES-1:0] counted;
  logic [MAX_DEVICES-1:0] cur_bit;
  logic [MAX_DEVICES-1:0] load_hit;
  logic [MAX_DEVICES-1:0] taking_part;
  logic [MAX_DEVICES-1:0] read_bit;
  logic [MASK_W-1:0]      mask_now;
  logic                   pos_in_id;
  logic                   level;
  logic [POS_W-1:0]       pos_inc;

  assign pos_in_id = (int'(pos_r) < ID_WIDTH);

  for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_lane
    assign counted[i]  = (int'(dev_count_r) > i);
    assign load_hit[i] = (int'(index_r) == i);
    assign cur_bit[i]  = pos_in_id ? id_store_r[i][pos_r[ID_IDX_W-1:0]] : 1'b0;

    always_ff @(posedge clk) begin
      if (cmd.op == OP_LOAD && load_hit[i]) begin
        id_store_r[i] <= new_id_r;
      end
    end
  end

  assign taking_part = counted & in_search_r;
  assign read_bit    = (phase_r == PHASE_SECOND) ? ~cur_bit : cur_bit;
  // Devices not taking part leave the pulled-up bus at one.
  assign level       = &(~taking_part | read_bit);

  always_comb begin
    mask_now = '0;
    for (int i = 0; i < MASK_LANES; i++) begin
      mask_now[i] = taking_part[i];
    end
  end

  assign pos_inc = (pos_r < POS_LIMIT) ? pos_r + POS_W'(1) : pos_r;

  always_comb begin
    in_search_nxt = in_search_r;
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    unique case (cmd.op)
      OP_LOAD: begin
        in_search_nxt = in_search_r | load_hit;
      end
      OP_RESET: begin
        in_search_nxt = in_search_r | counted;
        mode_nxt      = 1'b0;
        phase_nxt     = PHASE_FIRST;
        pos_nxt       = '0;
      end
      OP_START: begin
        mode_nxt = 1'b1;
      end
      OP_READ: begin
        phase_nxt = phase_r + PHASE_W'(1);
      end
      OP_WRITE: begin
        // Drop counted devices whose bit disagrees with the chosen direction.
        in_search_nxt = in_search_r &
                        ~(counted & (cur_bit ^ {MAX_DEVICES{dir_r}}));
        if (pos_inc >= bit_size_r) begin
          in_search_nxt = in_search_r & ~counted;
        end
        pos_nxt   = pos_inc;
        phase_nxt = PHASE_FIRST;
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_search_r <= '0;
      mode_r      <= 1'b0;
      phase_r     <= PHASE_FIRST;
      pos_r       <= '0;
      bit_size_r  <= BIT_SIZE_RST;
      dev_count_r <= DEV_COUNT_RST;
      valid_r     <= 1'b0;
    end else begin
      in_search_r <= in_search_nxt;
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      valid_r     <= (cmd.op == OP_READ);
      if (cfg_we) begin
        if (cfg_index == REG_BIT_SIZE) begin
          bit_size_r <= cfg_data[POS_W-1:0];
        end
        if (cfg_index == REG_DEVICE_COUNT) begin
          dev_count_r <= cfg_data[COUNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      index_r  <= in_device_index;
      new_id_r <= in_device_id[ID_WIDTH-1:0];
      dir_r    <= in_direction;
    end
    if (cmd.op == OP_READ) begin
      bus_bit_r <= level;
      mask_r    <= mask_now;
    end
  end

  assign sts.kind        = kind_r;
  assign sts.search_mode = mode_r;
  assign sts.phase       = phase_r;

  assign out_valid          = valid_r;
  assign out_bus_bit        = bus_bit_r;
  assign out_in_search_mask = mask_r;

endmodule

`default_nettype wire

// ===== rtl/core/onewire_search_rom_responder.sv =====
// ----------------------------------------------------------------------------
// 1-Wire Search ROM responder
// Emulates a bus of slave devices answering the Search ROM bit sequence.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Busy then stays high
// for exactly one cycle while the controller executes the item, so no new item
// is taken until the controller is idle again. A read item that is legal in the current
// mode and phase produces one result: out_valid is high for the single cycle
// that follows the busy cycle, with bus_bit and the in-search mask beside it.
// The result must be sampled in that cycle; nothing holds it. All other
// items produce no result. Configuration writes take effect at once and are
// expected only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "onewire_search_rom_responder_macros.svh"

module onewire_search_rom_responder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic [osr_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [osr_pkg::INDEX_W-1:0]    in_device_index,
  input  wire logic [osr_pkg::DEV_ID_W-1:0]   in_device_id,
  input  wire logic                           in_direction,
  output      logic                           out_valid,
  output      logic                           out_bus_bit,
  output      logic [osr_pkg::MASK_W-1:0]     out_in_search_mask,
  input  wire logic                           cfg_we,
  input  wire logic [osr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [osr_pkg::CFG_W-1:0]      cfg_data
);
  import osr_pkg::*;

  osr_cmd_t    cmd;
  osr_status_t sts;

  osr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  osr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_kind),
    .in_device_index    (in_device_index),
    .in_device_id       (in_device_id),
    .in_direction       (in_direction),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_bus_bit        (out_bus_bit),
    .out_in_search_mask (out_in_search_mask)
  );

  `OSR_ASSERT_NEXT(a_exec_one_cycle, busy, !busy, "execution lasted more than one cycle")
  `OSR_ASSERT_NEXT(a_result_single, out_valid, !out_valid, "results on consecutive cycles")
  `OSR_ASSERT_NOW(a_result_after_exec, out_valid, $past(busy), "result without an executed item")
  `OSR_ASSERT_NOW(a_op_only_when_busy, !busy, cmd.op == OP_NONE, "operation issued while idle")

endmodule

`default_nettype wire
